// File: sv/tt_pkg.sv
// Shared types and constants for the transposition table.
`default_nettype none

package tt_pkg;

  localparam int HASH_W      = 64;
  localparam int SCORE_W     = 16;
  localparam int DEPTH_SHIFT = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [SCORE_W-1:0] MISS_SCORE = SCORE_W'(1);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [HASH_W-1:0]  board_hash;
    logic [SCORE_W-1:0] new_score;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] found_score;
    logic               hit;
  } out_word_t;

  typedef struct packed {
    logic     valid;
    in_word_t word;
  } tt_head_t;

endpackage

`default_nettype wire

// File: sv/tt_front.sv
// Front end: accepts input words into a short queue ahead of the table engine.
`default_nettype none

module tt_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tt_pkg::in_word_t  in_word,
  input  wire logic              hold,
  output tt_pkg::tt_head_t       head,
  input  wire logic              pop
);

  tt_pkg::in_word_t               q_mem [0:tt_pkg::QDEPTH-1];
  logic [tt_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [tt_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [tt_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           push;
  logic                           do_pop;

  assign in_stall = hold || (cnt_r == tt_pkg::QCNT_W'(tt_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.word  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tt_pkg::QPTR_W'(tt_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + tt_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tt_pkg::QPTR_W'(tt_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + tt_pkg::QPTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + tt_pkg::QCNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - tt_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_word;
    end
  end

endmodule

`default_nettype wire

// File: sv/tt_back.sv
// Back end: entry memory, clearing sweep and read-modify-write engine.
`default_nettype none

module tt_back #(
  parameter int SLOT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tt_pkg::tt_head_t   head,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tt_pkg::out_word_t       out_word
);

  localparam int TAG_W   = tt_pkg::HASH_W - SLOT_BITS;
  localparam int ENTRY_W = TAG_W + tt_pkg::SCORE_W;
  localparam int DEPTH   = 1 << SLOT_BITS;
  localparam int DEP_W   = tt_pkg::SCORE_W - tt_pkg::DEPTH_SHIFT;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [ENTRY_W-1:0]         mem [0:DEPTH-1];
  logic [ENTRY_W-1:0]         rd_data_r;
  logic [SLOT_BITS-1:0]       rd_addr;
  logic                       mem_we;
  logic [SLOT_BITS-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]         mem_wdata;

  logic [1:0]                 state_r, state_nxt;
  logic [SLOT_BITS-1:0]       clr_addr_r, clr_addr_nxt;
  logic                       op_r;
  logic [SLOT_BITS-1:0]       slot_r;
  logic [TAG_W-1:0]           tag_r;
  logic [tt_pkg::SCORE_W-1:0] score_r;
  logic                       out_valid_r, out_valid_nxt;
  tt_pkg::out_word_t          out_word_r, out_word_nxt;

  logic [TAG_W-1:0]           stored_tag;
  logic [tt_pkg::SCORE_W-1:0] stored_score;
  logic                       tag_match;
  logic                       depth_ok;
  logic                       do_write;
  logic                       out_free;

  assign stored_tag   = rd_data_r[ENTRY_W-1:tt_pkg::SCORE_W];
  assign stored_score = rd_data_r[tt_pkg::SCORE_W-1:0];
  assign tag_match    = (stored_tag == tag_r);
  assign depth_ok     = (stored_score[tt_pkg::SCORE_W-1 -: DEP_W]
                         <= score_r[tt_pkg::SCORE_W-1 -: DEP_W]);
  assign do_write     = (state_r == ST_EXEC) && (op_r == tt_pkg::OP_STORE)
                        && (tag_match || depth_ok);

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == ST_IDLE) && head.valid && out_free;
  assign clearing = (state_r == ST_CLEAR);
  assign rd_addr  = head.word.board_hash[SLOT_BITS-1:0];

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = {tag_r, score_r};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (do_write) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + SLOT_BITS'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        if (op_r == tt_pkg::OP_LOOKUP) begin
          out_valid_nxt            = 1'b1;
          out_word_nxt.hit         = tag_match;
          out_word_nxt.found_score = tag_match ? stored_score : tt_pkg::MISS_SCORE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    if (pop) begin
      op_r    <= head.word.operation;
      slot_r  <= head.word.board_hash[SLOT_BITS-1:0];
      tag_r   <= head.word.board_hash[tt_pkg::HASH_W-1:SLOT_BITS];
      score_r <= head.word.new_score;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/transposition_table.sv
// Top level of the direct-mapped, depth-preferred transposition table.
//
//   channel   dir   handshake              word
//   in_       in    in_valid / in_stall    tt_pkg::in_word_t  (operation, board_hash, new_score)
//   out_      out   out_valid / out_stall  tt_pkg::out_word_t (found_score, hit)
//
// A word's entry is read as the word is popped in IDLE, then compared and written
// back in EXEC; the registered entry memory read sets that, and no new word is
// popped until EXEC is done. A two-word queue takes input while the engine or the
// output register waits. After reset all 2**SLOT_BITS entries are cleared, one per
// cycle, with in_stall high. Lookups give one output word each; stores give none.
`default_nettype none

module transposition_table #(
  parameter int SLOT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire tt_pkg::in_word_t  in_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tt_pkg::out_word_t      out_word
);

  tt_pkg::tt_head_t head;
  logic             pop;
  logic             clearing;

  tt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .hold     (clearing),
    .head     (head),
    .pop      (pop)
  );

  tt_back #(
    .SLOT_BITS (SLOT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: sim/tt_checker.sv
// Checker for the transposition table: predicts each lookup word and compares it at the output.
`default_nettype none

module tt_checker #(
  parameter int SLOT_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire tt_pkg::in_word_t  in_word,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire tt_pkg::out_word_t out_word,
  output int                     mismatch_count,
  output int                     lookups_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAG_W      = tt_pkg::HASH_W - SLOT_BITS;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [TAG_W-1:0]           tag;
    logic [tt_pkg::SCORE_W-1:0] score;
  } slot_entry_t;

  slot_entry_t       slots [logic [SLOT_BITS-1:0]];
  tt_pkg::out_word_t lookup_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic void apply_word(input tt_pkg::in_word_t w);
    logic [SLOT_BITS-1:0] slot;
    logic [TAG_W-1:0]     tag;
    slot_entry_t          cur;
    tt_pkg::out_word_t    res;
    slot = w.board_hash[SLOT_BITS-1:0];
    tag  = w.board_hash[tt_pkg::HASH_W-1:SLOT_BITS];
    cur  = slots.exists(slot) ? slots[slot] : '0;
    if (w.operation == tt_pkg::OP_LOOKUP) begin
      if (cur.tag == tag) begin
        res.found_score = cur.score;
        res.hit         = 1'b1;
      end else begin
        res.found_score = tt_pkg::MISS_SCORE;
        res.hit         = 1'b0;
      end
      lookup_results.push_back(res);
    end else if (cur.tag == tag ||
                 (cur.score >> tt_pkg::DEPTH_SHIFT)
                 <= (w.new_score >> tt_pkg::DEPTH_SHIFT)) begin
      slots[slot] = '{tag: tag, score: w.new_score};
    end
  endfunction

  always @(posedge clk) begin : watch
    tt_pkg::out_word_t want;
    if (!rst_n) begin
      slots.delete();
      lookup_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (lookup_results.size() == 0) begin
          report_mismatch("unexpected word", 32'(out_word), 32'd0);
        end else begin
          want = lookup_results.pop_front();
          if (out_word.found_score !== want.found_score) begin
            report_mismatch("found_score", 32'(out_word.found_score), 32'(want.found_score));
          end
          if (out_word.hit !== want.hit) begin
            report_mismatch("hit", 32'(out_word.hit), 32'(want.hit));
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_word(in_word);
      end
    end
    lookups_pending <= lookup_results.size();
  end

endmodule

`default_nettype wire

// File: sim/tb_transposition_table.sv
// Testbench top for the transposition table: reset, directed and random words, verdict.
`default_nettype none

module tb_transposition_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_BITS      = 16;
  localparam int TAG_W          = tt_pkg::HASH_W - SLOT_BITS;
  localparam int SLOT_POOL      = 8;
  localparam int TAG_POOL       = 4;
  localparam int PHASE_ITEMS    = 458;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 300000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  tt_pkg::in_word_t  in_word   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  tt_pkg::out_word_t out_word;

  int mismatch_count;
  int lookups_pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  logic [SLOT_BITS-1:0] slot_pool [SLOT_POOL];
  logic [TAG_W-1:0]     tag_pool  [TAG_POOL];

  logic [TAG_W-1:0]     tag_a;
  logic [TAG_W-1:0]     tag_b;
  logic [SLOT_BITS-1:0] slot_x;

  transposition_table #(.SLOT_BITS(SLOT_BITS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  tt_checker #(.SLOT_BITS(SLOT_BITS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .mismatch_count (mismatch_count),
    .lookups_pending(lookups_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("transposition_table test failed");
      $finish;
    end
  end

  function automatic tt_pkg::in_word_t make_word(input logic op,
                                                 input logic [tt_pkg::HASH_W-1:0] hash,
                                                 input logic [tt_pkg::SCORE_W-1:0] score);
    tt_pkg::in_word_t w;
    w.operation  = op;
    w.board_hash = hash;
    w.new_score  = score;
    return w;
  endfunction

  function automatic tt_pkg::in_word_t random_word();
    tt_pkg::in_word_t w;
    w.operation = 1'($urandom_range(1));
    if ($urandom_range(99) < 85) begin
      w.board_hash = {tag_pool[$urandom_range(TAG_POOL-1)],
                      slot_pool[$urandom_range(SLOT_POOL-1)]};
    end else begin
      w.board_hash = {$urandom, $urandom};
    end
    if ($urandom_range(1) == 1) begin
      w.new_score = 16'($urandom);
    end else begin
      w.new_score = {14'($urandom_range(7)), 2'($urandom)};
    end
    return w;
  endfunction

  task automatic send_word(input tt_pkg::in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every lookup word is back, then let stores settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (lookups_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    slot_pool[0] = '0;
    slot_pool[1] = '1;
    for (int i = 2; i < SLOT_POOL; i++) slot_pool[i] = SLOT_BITS'($urandom);
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL; i++) tag_pool[i] = TAG_W'({$urandom, $urandom});
    tag_a  = TAG_W'({$urandom, $urandom}) | TAG_W'(1);
    tag_b  = ~tag_a;
    slot_x = SLOT_BITS'($urandom_range(1, (1 << SLOT_BITS) - 2));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(make_word(tt_pkg::OP_LOOKUP, '0, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, '1, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, {{TAG_W{1'b0}}, {SLOT_BITS{1'b1}}}, '1));
    send_word(make_word(tt_pkg::OP_STORE, {tag_a, slot_x}, {14'd5, 2'd2}));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_a, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_STORE, {tag_a, slot_x}, {14'd2, 2'd1}));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_a, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_STORE, {tag_b, slot_x}, {14'd2, 2'd3}));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_a, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_b, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_STORE, {tag_a, slot_x}, {14'd1, 2'd0}));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_b, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_STORE, {tag_a, slot_x}, {14'd3, 2'd0}));
    send_word(make_word(tt_pkg::OP_LOOKUP, {tag_a, slot_x}, '0));
    send_word(make_word(tt_pkg::OP_STORE, '1, '1));
    send_word(make_word(tt_pkg::OP_LOOKUP, '1, '0));
    send_word(make_word(tt_pkg::OP_STORE, {{TAG_W{1'b0}}, {SLOT_BITS{1'b1}}}, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, {{TAG_W{1'b0}}, {SLOT_BITS{1'b1}}}, '0));
    send_word(make_word(tt_pkg::OP_STORE, '0, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, '0, '1));
    send_word(make_word(tt_pkg::OP_STORE, {{TAG_W{1'b1}}, {SLOT_BITS{1'b0}}}, '0));
    send_word(make_word(tt_pkg::OP_LOOKUP, '0, '0));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (PHASE_ITEMS) send_word(random_word());
      drain();
    end

    if (mismatch_count == 0 && lookups_pending == 0) begin
      $display("transposition_table test passed");
    end else begin
      $display("transposition_table test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
